// ===== rtl/fwpsl_pkg.sv =====
`timescale 1ns / 1ps
package fwpsl_pkg;

    localparam int WHEELS   = 4;
    localparam int WIDX_W   = $clog2(WHEELS);
    localparam int FIELD_W  = 16;
    localparam int CAP_W    = 8;
    localparam int SCALE_W  = 20;
    localparam int CLAMP_W  = 15;
    localparam int CFG_W    = SCALE_W;
    localparam int CFG_IDX_W = 2;
    localparam int DEM_W    = 2 * FIELD_W - 1;          // |w*c| <= 2^30
    localparam int SUM_W    = DEM_W + WIDX_W;
    localparam int SHARE_W  = 24;                       // Q8.16 watts
    localparam int FRAC_W   = 16;
    localparam int BOUND_W  = SHARE_W + SCALE_W - FRAC_W;
    localparam int MUL_A_W  = DEM_W;
    localparam int MUL_B_W  = SCALE_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int NUM_W    = DEM_W + CAP_W;            // demand*cap before the <<16

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_CAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_CLAMP = 2'd2;

    localparam logic [CAP_W-1:0]   RST_POWER_CAP     = 8'd70;
    localparam logic [SCALE_W-1:0] RST_BOUND_SCALE   = 20'd472723;
    localparam logic [CLAMP_W-1:0] RST_CURRENT_CLAMP = 15'd7000;

    typedef struct packed {
        logic signed [FIELD_W-1:0] need_current_lf;
        logic signed [FIELD_W-1:0] need_current_rf;
        logic signed [FIELD_W-1:0] need_current_rb;
        logic signed [FIELD_W-1:0] need_current_lb;
        logic signed [FIELD_W-1:0] speed_lf;
        logic signed [FIELD_W-1:0] speed_rf;
        logic signed [FIELD_W-1:0] speed_rb;
        logic signed [FIELD_W-1:0] speed_lb;
        logic signed [FIELD_W-1:0] weight_lf;
        logic signed [FIELD_W-1:0] weight_rf;
        logic signed [FIELD_W-1:0] weight_rb;
        logic signed [FIELD_W-1:0] weight_lb;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] limited_current_lf;
        logic signed [FIELD_W-1:0] limited_current_rf;
        logic signed [FIELD_W-1:0] limited_current_rb;
        logic signed [FIELD_W-1:0] limited_current_lb;
    } t_out;

endpackage

// ===== rtl/four_wheel_power_share_limiter.sv =====
`timescale 1ns / 1ps
// Power-share limiter for four wheels. One beat carries requested currents,
// speeds and weights; one beat of limited currents comes back per input beat.
// A single 31x20 multiplier and a single restoring divider (one quotient bit
// per cycle) are time-shared by a sequencer. An item is shortest with no demand
// and no wheel limited, and longest with every share recomputed with 24 divide
// steps and every wheel limited with a 28-step bound/speed division. The input
// side is stalled until the item is pushed out; a finished result sits in the
// output register so a new beat can be taken while it waits. Configuration
// writes are meant for idle periods only.
module four_wheel_power_share_limiter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  fwpsl_pkg::t_in                    i_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output fwpsl_pkg::t_out                   o_out,
    input  logic                              i_cfg_we,
    input  logic [fwpsl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fwpsl_pkg::CFG_W-1:0]       i_cfg_data
);
    import fwpsl_pkg::*;

    localparam int RW   = SUM_W + 1;
    localparam int QW   = BOUND_W;
    localparam int CW   = BOUND_W + 1;
    localparam int CNT_W = $clog2(QW);

    typedef enum logic [3:0] {
        S_IDLE, S_DEM, S_DEM_ACC, S_SH, S_SH_LD, S_SH_DIV,
        S_BND, S_BND_LD, S_CS, S_CS_CHK, S_LDIV, S_CLAMP, S_PUSH
    } t_state;

    t_state                     r_state;
    t_in                        r_in;
    logic [WIDX_W-1:0]          r_w;
    logic [CAP_W-1:0]           r_cap;
    logic [SCALE_W-1:0]         r_scale;
    logic [CLAMP_W-1:0]         r_clamp;
    logic [SHARE_W-1:0]         r_share [WHEELS];
    logic [DEM_W-1:0]           r_dem [WHEELS];
    logic [SUM_W-1:0]           r_sum;
    logic [PROD_W-1:0]          r_prod;
    logic [BOUND_W-1:0]         r_bound;
    logic [RW-1:0]              r_rem;
    logic [QW-1:0]              r_q;
    logic [SUM_W-1:0]           r_div;
    logic [CNT_W-1:0]           r_cnt;
    logic [CNT_W-1:0]           r_last;
    logic signed [CW-1:0]       r_c;
    logic signed [FIELD_W-1:0]  r_res [WHEELS];
    logic                       r_ovalid;
    t_out                       r_out;

    logic signed [FIELD_W-1:0]  cur [WHEELS];
    logic signed [FIELD_W-1:0]  spd [WHEELS];
    logic signed [FIELD_W-1:0]  wt  [WHEELS];
    logic [FIELD_W-1:0]         cur_mag;
    logic [FIELD_W-1:0]         spd_mag;
    logic [FIELD_W-1:0]         wt_mag;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [SUM_W-1:0]           n_sum;
    logic [RW-1:0]              rem_sh;
    logic                       q_bit;
    logic [RW-1:0]              rem_nx;
    logic signed [CW-1:0]       lim;
    logic signed [CW-1:0]       c_cl;
    logic                       w_last;
    logic                       out_free;

    function automatic logic [FIELD_W-1:0] mag16(input logic signed [FIELD_W-1:0] v);
        mag16 = v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
    endfunction

    always_comb begin
        cur[0] = r_in.need_current_lf; cur[1] = r_in.need_current_rf;
        cur[2] = r_in.need_current_rb; cur[3] = r_in.need_current_lb;
        spd[0] = r_in.speed_lf;  spd[1] = r_in.speed_rf;
        spd[2] = r_in.speed_rb;  spd[3] = r_in.speed_lb;
        wt[0]  = r_in.weight_lf; wt[1]  = r_in.weight_rf;
        wt[2]  = r_in.weight_rb; wt[3]  = r_in.weight_lb;
    end

    assign cur_mag = mag16(cur[r_w]);
    assign spd_mag = mag16(spd[r_w]);
    assign wt_mag  = mag16(wt[r_w]);
    assign w_last  = (r_w == WIDX_W'(WHEELS - 1));
    assign n_sum   = r_sum + SUM_W'(r_prod[DEM_W-1:0]);

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_DEM: begin
                mul_a = MUL_A_W'(wt_mag);
                mul_b = MUL_B_W'(cur_mag);
            end
            S_SH: begin
                mul_a = r_dem[r_w];
                mul_b = MUL_B_W'(r_cap);
            end
            S_BND: begin
                mul_a = MUL_A_W'(r_share[r_w]);
                mul_b = r_scale;
            end
            default: begin
                mul_a = MUL_A_W'(r_c[CW-1] ? CW'(-r_c) : CW'(r_c));
                mul_b = MUL_B_W'(spd_mag);
            end
        endcase
    end

    // one restoring divide step
    assign rem_sh = {r_rem[RW-2:0], r_q[QW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_div});
    assign rem_nx = q_bit ? rem_sh - {1'b0, r_div} : rem_sh;

    assign lim  = CW'($signed({1'b0, r_clamp}));
    always_comb begin
        priority if (r_c > lim)  c_cl = lim;
        else if (r_c < -lim)     c_cl = -lim;
        else                     c_cl = r_c;
    end

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_out    = r_out;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cap    <= RST_POWER_CAP;
            r_scale  <= RST_BOUND_SCALE;
            r_clamp  <= RST_CURRENT_CLAMP;
            r_w      <= '0;
            r_sum    <= '0;
            for (int i = 0; i < WHEELS; i++) r_share[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POWER_CAP:     r_cap   <= i_cfg_data[CAP_W-1:0];
                    CFG_BOUND_SCALE:   r_scale <= i_cfg_data[SCALE_W-1:0];
                    CFG_CURRENT_CLAMP: r_clamp <= i_cfg_data[CLAMP_W-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall && r_state != S_PUSH) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in    <= i_in;
                        r_w     <= '0;
                        r_sum   <= '0;
                        r_state <= S_DEM;
                    end
                end
                S_DEM: r_state <= S_DEM_ACC;
                S_DEM_ACC: begin
                    r_dem[r_w] <= r_prod[DEM_W-1:0];
                    r_sum      <= n_sum;
                    if (!w_last) begin
                        r_w     <= r_w + 1'b1;
                        r_state <= S_DEM;
                    end else begin
                        r_w     <= '0;
                        // zero total demand: keep the old shares
                        r_state <= (n_sum == '0) ? S_BND : S_SH;
                    end
                end
                S_SH: r_state <= S_SH_LD;
                S_SH_LD: begin
                    r_rem   <= RW'(r_prod[NUM_W-1:SHARE_W-FRAC_W]);
                    r_q     <= QW'({r_prod[SHARE_W-FRAC_W-1:0], {FRAC_W{1'b0}}})
                               << (QW - SHARE_W);
                    r_div   <= r_sum;
                    r_cnt   <= '0;
                    r_last  <= CNT_W'(SHARE_W - 1);
                    r_state <= S_SH_DIV;
                end
                S_SH_DIV: begin
                    r_rem <= rem_nx;
                    r_q   <= {r_q[QW-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_last) begin
                        r_share[r_w] <= {r_q[SHARE_W-2:0], q_bit};
                        if (!w_last) begin
                            r_w     <= r_w + 1'b1;
                            r_state <= S_SH;
                        end else begin
                            r_w     <= '0;
                            r_state <= S_BND;
                        end
                    end
                end
                S_BND: r_state <= S_BND_LD;
                S_BND_LD: begin
                    r_bound <= r_prod[FRAC_W +: BOUND_W];
                    r_c     <= CW'(cur[r_w]);
                    r_state <= S_CS;
                end
                S_CS: r_state <= S_CS_CHK;
                S_CS_CHK: begin
                    if (spd[r_w] != '0 && r_prod > PROD_W'(r_bound)) begin
                        r_rem   <= '0;
                        r_q     <= r_bound;
                        r_div   <= SUM_W'(spd_mag);
                        r_cnt   <= '0;
                        r_last  <= CNT_W'(QW - 1);
                        r_state <= S_LDIV;
                    end else begin
                        r_state <= S_CLAMP;
                    end
                end
                S_LDIV: begin
                    r_rem <= rem_nx;
                    r_q   <= {r_q[QW-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_last) begin
                        // both limit branches give sign(current) * bound/|speed|
                        r_c <= cur[r_w][FIELD_W-1] ? -CW'({r_q[QW-2:0], q_bit})
                                                   :  CW'({r_q[QW-2:0], q_bit});
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_res[r_w] <= c_cl[FIELD_W-1:0];
                    if (!w_last) begin
                        r_w     <= r_w + 1'b1;
                        r_state <= S_BND;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out.limited_current_lf <= r_res[0];
                        r_out.limited_current_rf <= r_res[1];
                        r_out.limited_current_rb <= r_res[2];
                        r_out.limited_current_lb <= r_res[3];
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_state == S_DEM)
        else $error("accepted beat did not start the sequencer");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_DIV || r_state == S_LDIV) |-> r_rem < {1'b0, r_div})
        else $error("divider remainder out of range");

    a_res_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PUSH |-> (r_res[0] <= $signed({1'b0, r_clamp})
                               && r_res[0] >= -$signed({1'b0, r_clamp})))
        else $error("result exceeds current clamp");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import fwpsl_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_in;
    logic        o_valid;
    logic        i_stall;
    t_out        o_out;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    four_wheel_power_share_limiter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [CAP_W-1:0]   cap_q;
    logic [SCALE_W-1:0] scale_q;
    logic [CLAMP_W-1:0] clamp_q;
    logic [SHARE_W-1:0] share_q [WHEELS];

    t_out   limited_q [$];
    int     mismatches;
    longint cycles;
    int     send_idle_pct;
    int     recv_idle_pct;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic t_out predict_limits(input t_in it);
        logic signed [FIELD_W-1:0] cur [WHEELS];
        logic signed [FIELD_W-1:0] spd [WHEELS];
        logic signed [FIELD_W-1:0] wgt [WHEELS];
        longint demand [WHEELS];
        longint sum;
        longint bound;
        longint c;
        longint s;
        longint lim;
        t_out r;
        cur = '{it.need_current_lf, it.need_current_rf, it.need_current_rb,
                it.need_current_lb};
        spd = '{it.speed_lf, it.speed_rf, it.speed_rb, it.speed_lb};
        wgt = '{it.weight_lf, it.weight_rf, it.weight_rb, it.weight_lb};
        sum = 0;
        for (int i = 0; i < WHEELS; i++) begin
            demand[i] = longint'(wgt[i]) * longint'(cur[i]);
            if (demand[i] < 0) demand[i] = -demand[i];
            sum += demand[i];
        end
        if (sum != 0)
            for (int i = 0; i < WHEELS; i++)
                share_q[i] = SHARE_W'(((demand[i] * longint'(cap_q)) <<< 16) / sum);
        lim = longint'(clamp_q);
        for (int i = 0; i < WHEELS; i++) begin
            bound = (longint'(share_q[i]) * longint'(scale_q)) >>> 16;
            c = cur[i];
            s = spd[i];
            if (s != 0) begin
                if (c * s > bound) c = bound / s;
                if (c * s < -bound) c = -bound / s;
            end
            if (c > lim) c = lim;
            if (c < -lim) c = -lim;
            case (i)
                0: r.limited_current_lf = FIELD_W'(c);
                1: r.limited_current_rf = FIELD_W'(c);
                2: r.limited_current_rb = FIELD_W'(c);
                default: r.limited_current_lb = FIELD_W'(c);
            endcase
        end
        return r;
    endfunction

    // compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (limited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", o_out);
            end else begin
                exp_r = limited_q.pop_front();
                if (exp_r !== o_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp lf %0d rf %0d rb %0d lb %0d got %0d %0d %0d %0d",
                                 exp_r.limited_current_lf, exp_r.limited_current_rf,
                                 exp_r.limited_current_rb, exp_r.limited_current_lb,
                                 o_out.limited_current_lf, o_out.limited_current_rf,
                                 o_out.limited_current_rb, o_out.limited_current_lb);
                end
            end
        end
    end

    task automatic send_tick(input t_in it);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid <= 1'b1;
        i_in    <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        limited_q.push_back(predict_limits(it));
        // drop valid so that the block, idle again, does not take this beat a second time
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (limited_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_POWER_CAP) cap_q = CAP_W'(val);
        else if (idx == CFG_BOUND_SCALE) scale_q = SCALE_W'(val);
        else if (idx == CFG_CURRENT_CLAMP) clamp_q = CLAMP_W'(val);
        @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_field();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            3: return FIELD_W'($urandom_range(200)) - 16'd100;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic t_in rand_tick();
        t_in it;
        it = t_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        for (int k = 0; k < 12; k++)
            if ($urandom_range(3) == 0) it[k*FIELD_W +: FIELD_W] = pick_field();
        // leave the whole demand at zero now and then to hold the shares
        if ($urandom_range(15) == 0) begin
            it.weight_lf = '0; it.weight_rf = '0; it.weight_rb = '0; it.weight_lb = '0;
        end
        return it;
    endfunction

    task automatic test_directed;
        t_in it;
        // zero demand right after reset: bounds are zero
        it = '0;
        it.need_current_lf = 16'sd500; it.speed_lf = 16'sd10;
        send_tick(it);
        it = '0;
        send_tick(it);
        it = '1;
        send_tick(it);
        it = '{default: 16'sh8000};
        send_tick(it);
        it = '{default: 16'sh7FFF};
        send_tick(it);
        it = '{default: 16'sh7FFF};
        it.speed_lf = 16'sh8000; it.need_current_rf = 16'sh8000;
        send_tick(it);
        // zero speed: clamp only
        it = '{default: 16'sd1};
        it.need_current_lf = 16'sd20000; it.need_current_rb = -16'sd20000;
        it.speed_lf = 0; it.speed_rb = 0;
        send_tick(it);
        // negative speed on both signs of current, both products within the bound
        it = '{default: 16'sd3};
        it.need_current_lf = -16'sd3000; it.speed_lf = -16'sd300;
        it.need_current_rf = 16'sd3000; it.speed_rf = -16'sd300;
        send_tick(it);
        for (int k = 0; k < 12; k++) send_tick(rand_tick());
        drain();
    endtask

    task automatic test_config_extremes;
        write_reg(CFG_POWER_CAP, 0);
        write_reg(CFG_BOUND_SCALE, 0);
        write_reg(CFG_CURRENT_CLAMP, 0);
        write_reg(CFG_UNUSED, 12345);
        repeat (8) send_tick(rand_tick());
        drain();
        write_reg(CFG_POWER_CAP, 255);
        write_reg(CFG_BOUND_SCALE, 1048575);
        write_reg(CFG_CURRENT_CLAMP, 32767);
        repeat (8) send_tick(rand_tick());
        drain();
    endtask

    task automatic test_random(input int count, input int sp, input int rp);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        write_reg(CFG_POWER_CAP, $urandom_range(255));
        write_reg(CFG_BOUND_SCALE, $urandom_range(1048575));
        write_reg(CFG_CURRENT_CLAMP, $urandom_range(32767));
        repeat (count) send_tick(rand_tick());
        drain();
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_in = '0; i_stall = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        cycles = 0; mismatches = 0; send_idle_pct = 35; recv_idle_pct = 80;
        cap_q = RST_POWER_CAP; scale_q = RST_BOUND_SCALE; clamp_q = RST_CURRENT_CLAMP;
        for (int i = 0; i < WHEELS; i++) share_q[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        write_reg(CFG_POWER_CAP, RST_POWER_CAP);
        write_reg(CFG_BOUND_SCALE, RST_BOUND_SCALE);
        write_reg(CFG_CURRENT_CLAMP, RST_CURRENT_CLAMP);
        test_random(300, 35, 80);
        test_random(300, 80, 35);
        test_random(300, 0, 0);
        test_random(300, 0, 0);
        if (mismatches == 0 && limited_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/fwpsl_pkg.sv
rtl/four_wheel_power_share_limiter.sv
bench/tb.sv
